/* hw/rtl/lcbd_pkg.sv */
// Shared types, constants and the colour decode for the LED colour blink deque.
`default_nettype none

package lcbd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COLOUR_W    = 3;
  localparam int ACTION_W    = 2;
  localparam int TICK_W      = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TICK_W-1:0] ON_TICKS_RESET   = 16'd100;
  localparam logic [TICK_W-1:0] GAP_TICKS_RESET  = 16'd50;
  localparam logic [TICK_W-1:0] IDLE_TICKS_RESET = 16'd10;

  localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_PUSH   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_LIT   = 2'd1,
    PH_GAP   = 2'd2,
    PH_IDLE  = 2'd3
  } phase_t;

  typedef enum logic {
    ST_ACCEPT = 1'b0,
    ST_EXEC   = 1'b1
  } ctrl_state_t;

  // One update of the deque, valid for a single cycle.
  typedef struct packed {
    logic                append;
    logic                push;
    logic                pop;
    logic [COLOUR_W-1:0] colour;
  } queue_op_t;

  typedef struct packed {
    logic                empty;
    logic                full;
    logic [COLOUR_W-1:0] head_colour;
  } queue_status_t;

  // Pins as {blue, green, red}.
  function automatic logic [2:0] colour_pins(input logic [COLOUR_W-1:0] code);
    logic [2:0] pins;
    unique case (code)
      3'd0:    pins = 3'b001;
      3'd1:    pins = 3'b010;
      3'd2:    pins = 3'b100;
      3'd3:    pins = 3'b011;
      3'd4:    pins = 3'b101;
      3'd5:    pins = 3'b110;
      3'd6:    pins = 3'b111;
      default: pins = 3'b000;
    endcase
    return pins;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lcbd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/lcbd_queue.sv */
// Ring-buffer deque: head, tail and count registers around the colour RAM.
`default_nettype none

module lcbd_queue
  import lcbd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire queue_op_t     op,
  output      queue_status_t status,
  output      logic          full_next
);

  logic [IDX_W-1:0] head_index;
  logic [IDX_W-1:0] head_index_next;
  logic [IDX_W-1:0] tail_index;
  logic [IDX_W-1:0] tail_index_next;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] stored_count_next;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [COLOUR_W-1:0] ram_rdata;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  assign head_dec = (head_index == '0) ? LAST_IDX : head_index - IDX_W'(1);
  assign head_inc = (head_index == LAST_IDX) ? '0 : head_index + IDX_W'(1);
  assign tail_inc = (tail_index == LAST_IDX) ? '0 : tail_index + IDX_W'(1);

  always_comb begin
    head_index_next   = head_index;
    tail_index_next   = tail_index;
    stored_count_next = stored_count;
    ram_we            = 1'b0;
    ram_waddr         = tail_index;
    if (op.append) begin
      ram_we            = 1'b1;
      ram_waddr         = tail_index;
      tail_index_next   = tail_inc;
      stored_count_next = stored_count + CNT_W'(1);
    end else if (op.push) begin
      ram_we            = 1'b1;
      ram_waddr         = head_dec;
      head_index_next   = head_dec;
      stored_count_next = stored_count + CNT_W'(1);
    end else if (op.pop) begin
      head_index_next   = head_inc;
      stored_count_next = stored_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index   <= '0;
      tail_index   <= '0;
      stored_count <= '0;
    end else begin
      head_index   <= head_index_next;
      tail_index   <= tail_index_next;
      stored_count <= stored_count_next;
    end
  end

  // The head is read every cycle through the RAM's registered read port.
  lcbd_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(op.colour),
    .raddr(head_index),
    .rdata(ram_rdata)
  );

  assign status.empty       = (stored_count == '0);
  assign status.full        = (stored_count >= CNT_W'(QUEUE_DEPTH));
  assign status.head_colour = ram_rdata;
  assign full_next          = (stored_count_next >= CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

/* hw/rtl/lcbd_blink.sv */
// Blink sequencer: ready, lit, gap and idle phases with a shared tick timer.
`default_nettype none

module lcbd_blink
  import lcbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                tick,
  input  wire logic [TICK_W-1:0]   on_ticks,
  input  wire logic [TICK_W-1:0]   gap_ticks,
  input  wire logic [TICK_W-1:0]   idle_ticks,
  input  wire queue_status_t       status,
  output      logic                pop,
  output      logic [2:0]          pins_next
);

  phase_t              phase;
  phase_t              phase_next;
  logic [TICK_W-1:0]   phase_timer;
  logic [TICK_W-1:0]   phase_timer_next;
  logic [COLOUR_W-1:0] lit_colour;
  logic [COLOUR_W-1:0] lit_colour_next;
  logic                go_ready;

  always_comb begin
    phase_next       = phase;
    phase_timer_next = phase_timer;
    lit_colour_next  = lit_colour;
    go_ready         = 1'b0;
    if (tick) begin
      unique case (phase)
        PH_READY: go_ready = 1'b1;
        PH_LIT: begin
          if (phase_timer != '0) begin
            phase_timer_next = phase_timer - TICK_W'(1);
          end else if (gap_ticks != '0) begin
            phase_next       = PH_GAP;
            phase_timer_next = gap_ticks - TICK_W'(1);
          end else begin
            go_ready = 1'b1;
          end
        end
        PH_GAP, PH_IDLE: begin
          if (phase_timer != '0) begin
            phase_timer_next = phase_timer - TICK_W'(1);
          end else begin
            go_ready = 1'b1;
          end
        end
        default: phase_next = phase;
      endcase
    end
    // A poll pops the head colour, or waits idle, or stays ready when idle is zero.
    if (go_ready) begin
      if (!status.empty) begin
        phase_next       = PH_LIT;
        lit_colour_next  = status.head_colour;
        phase_timer_next = (on_ticks == '0) ? '0 : on_ticks - TICK_W'(1);
      end else if (idle_ticks == '0) begin
        phase_next = PH_READY;
      end else begin
        phase_next       = PH_IDLE;
        phase_timer_next = idle_ticks - TICK_W'(1);
      end
    end
  end

  always_comb begin
    pop       = go_ready && !status.empty;
    pins_next = (phase_next == PH_LIT) ? colour_pins(lit_colour_next) : 3'b000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_READY;
      phase_timer <= '0;
      lit_colour  <= '0;
    end else begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      lit_colour  <= lit_colour_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/led_colour_blink_deque.sv */
// A word taken into the request register is worked on in the EXEC state, then its result goes to the result register.
// No new word is taken while one is in the EXEC state; the colour RAM's registered read sets this.
// A result waiting in the result register holds the input off until it is taken.
// Reset (rst, synchronous): deque empty, sequencer ready, timer and lit colour cleared,
// result register empty, registers back to on 100, gap 50, idle 10 ticks. RAM not cleared.
`default_nettype none

module led_colour_blink_deque
  import lcbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [TICK_W-1:0]     cfg_data,
  // request channel
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [ACTION_W-1:0]   action,
  input  wire logic [COLOUR_W-1:0]   colour,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic                  accepted,
  output      logic                  queue_full,
  output      logic                  led_red,
  output      logic                  led_green,
  output      logic                  led_blue
);

  ctrl_state_t         state;
  ctrl_state_t         state_next;
  logic                in_fire;
  logic                exec;
  action_t             action_q;
  logic [COLOUR_W-1:0] colour_q;
  logic [TICK_W-1:0]   on_ticks;
  logic [TICK_W-1:0]   gap_ticks;
  logic [TICK_W-1:0]   idle_ticks;
  queue_op_t           op;
  queue_status_t       status;
  logic                full_next;
  logic                pop;
  logic [2:0]          pins_next;
  logic                add_req;
  logic                add_ok;

  // Configuration registers: writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks   <= ON_TICKS_RESET;
      gap_ticks  <= GAP_TICKS_RESET;
      idle_ticks <= IDLE_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_TICKS:   on_ticks   <= cfg_data;
        REG_GAP_TICKS:  gap_ticks  <= cfg_data;
        REG_IDLE_TICKS: idle_ticks <= cfg_data;
        default:        on_ticks   <= on_ticks;
      endcase
    end
  end

  // Control: take a word, then work on it in the EXEC state while the head word arrives from RAM.
  always_comb begin
    unique case (state)
      ST_ACCEPT: state_next = in_fire ? ST_EXEC : ST_ACCEPT;
      ST_EXEC:   state_next = ST_ACCEPT;
      default:   state_next = ST_ACCEPT;
    endcase
  end

  // Hold the input off while working, or while the result register stays full.
  always_comb begin
    in_stall = (state == ST_EXEC) || (out_valid && out_stall);
    in_fire  = in_valid && !in_stall;
    exec     = (state == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request word; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_q <= action_t'(action);
      colour_q <= colour;
    end
  end

  // Add requests are stored only while there is room; a tick may pop the head.
  assign add_req   = exec && ((action_q == ACT_APPEND) || (action_q == ACT_PUSH));
  assign add_ok    = add_req && !status.full;
  assign op.append = add_ok && (action_q == ACT_APPEND);
  assign op.push   = add_ok && (action_q == ACT_PUSH);
  assign op.pop    = pop;
  assign op.colour = colour_q;

  lcbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .status   (status),
    .full_next(full_next)
  );

  lcbd_blink u_blink (
    .clk       (clk),
    .rst       (rst),
    .tick      (exec && (action_q == ACT_TICK)),
    .on_ticks  (on_ticks),
    .gap_ticks (gap_ticks),
    .idle_ticks(idle_ticks),
    .status    (status),
    .pop       (pop),
    .pins_next (pins_next)
  );

  // Result register: load at the end of the working cycle, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      accepted   <= add_ok;
      queue_full <= full_next;
      led_red    <= pins_next[0];
      led_green  <= pins_next[1];
      led_blue   <= pins_next[2];
    end
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking bench for the LED colour blink deque: directed and random request words.
module testbench;
  import lcbd_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Random words sent under each timing setting.
  localparam int PHASE_WORDS = 75;
  localparam int PHASE_COUNT = 11;

  // Index with no register behind it; writes there must leave the timing untouched.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [COLOUR_W-1:0] COL_RED   = 3'd0;
  localparam logic [COLOUR_W-1:0] COL_WHITE = 3'd6;
  localparam logic [COLOUR_W-1:0] COL_DARK  = 3'd7;

  // LED pins per colour code, three bits each as {blue, green, red}, code 0 lowest.
  localparam logic [23:0] PIN_TABLE = {3'b000, 3'b111, 3'b110, 3'b101,
                                       3'b011, 3'b100, 3'b010, 3'b001};

  typedef struct packed {
    logic accepted;
    logic queue_full;
    logic led_red;
    logic led_green;
    logic led_blue;
  } led_report_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ON_TICKS;
  logic [TICK_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [ACTION_W-1:0]  action    = ACT_TICK;
  logic [COLOUR_W-1:0]  colour    = COL_RED;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 accepted;
  logic                 queue_full;
  logic                 led_red;
  logic                 led_green;
  logic                 led_blue;

  // Shadow of the block: deque contents, sequencer state and timing registers.
  logic [COLOUR_W-1:0] deque_slot [QUEUE_DEPTH];
  logic [IDX_W-1:0]    deque_front = '0;
  logic [IDX_W-1:0]    deque_back  = '0;
  logic [CNT_W-1:0]    deque_fill  = '0;
  phase_t              seq_phase   = PH_READY;
  logic [TICK_W-1:0]   seq_timer   = '0;
  logic [COLOUR_W-1:0] seq_colour  = '0;
  logic [TICK_W-1:0]   lit_len     = ON_TICKS_RESET;
  logic [TICK_W-1:0]   gap_len     = GAP_TICKS_RESET;
  logic [TICK_W-1:0]   idle_len    = IDLE_TICKS_RESET;

  led_report_t led_report_due[$];
  int          fault_count  = 0;
  int          quiet_cycles = 0;
  int          rx_hold      = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;

  led_colour_blink_deque DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .colour    (colour),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accepted  (accepted),
    .queue_full(queue_full),
    .led_red   (led_red),
    .led_green (led_green),
    .led_blue  (led_blue)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One time tick of the sequencer. Zero-length phases fall through within the
  // same tick; bound the fall-through as the block does.
  function automatic void advance_sequencer();
    for (int hop = 0; hop < 8; hop++) begin
      case (seq_phase)
        PH_READY: begin
          if (deque_fill != 0) begin
            seq_colour  = deque_slot[deque_front];
            deque_front = IDX_W'((int'(deque_front) + 1) % QUEUE_DEPTH);
            deque_fill  = deque_fill - 1'b1;
            seq_phase   = PH_LIT;
            // a zero on time still lights for one tick
            seq_timer   = (lit_len != 0) ? lit_len : TICK_W'(1);
          end else if (idle_len == 0) begin
            return;
          end else begin
            seq_phase = PH_IDLE;
            seq_timer = idle_len;
          end
        end
        PH_LIT: begin
          if (seq_timer != 0) begin
            seq_timer = seq_timer - 1'b1;
            return;
          end
          seq_phase = PH_GAP;
          seq_timer = gap_len;
        end
        default: begin
          if (seq_timer != 0) begin
            seq_timer = seq_timer - 1'b1;
            return;
          end
          seq_phase = PH_READY;
        end
      endcase
    end
  endfunction

  // Apply one request word to the shadow and return the report it must produce.
  function automatic led_report_t predict_word(input action_t act,
                                               input logic [COLOUR_W-1:0] col);
    led_report_t rep;
    logic [2:0]  pins;
    rep = '0;
    case (act)
      ACT_TICK: advance_sequencer();
      ACT_APPEND: begin
        if (deque_fill < QUEUE_DEPTH) begin
          deque_slot[deque_back] = col;
          deque_back   = IDX_W'((int'(deque_back) + 1) % QUEUE_DEPTH);
          deque_fill   = deque_fill + 1'b1;
          rep.accepted = 1'b1;
        end
      end
      ACT_PUSH: begin
        if (deque_fill < QUEUE_DEPTH) begin
          deque_front = IDX_W'((int'(deque_front) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
          deque_slot[deque_front] = col;
          deque_fill   = deque_fill + 1'b1;
          rep.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    pins = (seq_phase == PH_LIT) ? PIN_TABLE[int'(seq_colour) * 3 +: 3] : 3'b000;
    rep.queue_full = (deque_fill >= QUEUE_DEPTH);
    rep.led_red    = pins[0];
    rep.led_green  = pins[1];
    rep.led_blue   = pins[2];
    return rep;
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fault_count++;
    end
  endfunction

  // Send one request word: idle for a drawn number of cycles, then hold the word
  // until the block takes it, and queue its expected report on acceptance.
  task automatic send_word(input action_t act, input logic [COLOUR_W-1:0] col);
    int unsigned pause;
    pause = tx_gaps_on ? $urandom_range(0, 9) : 0;
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    colour   <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    led_report_due.insert(led_report_due.size(), predict_word(act, col));
  endtask

  // Stop sending and wait for every outstanding report; the block is then idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (led_report_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all three timing registers back to back, then a junk write to the spare
  // index, which must not disturb any of them. Call only with the block idle.
  task automatic apply_timing(input logic [TICK_W-1:0] on_t, input logic [TICK_W-1:0] gap_t,
                              input logic [TICK_W-1:0] idle_t);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ON_TICKS;
    cfg_data  <= on_t;
    @(posedge clk);
    cfg_index <= REG_GAP_TICKS;
    cfg_data  <= gap_t;
    @(posedge clk);
    cfg_index <= REG_IDLE_TICKS;
    cfg_data  <= idle_t;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= TICK_W'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    lit_len  = on_t;
    gap_len  = gap_t;
    idle_len = idle_t;
  endtask

  // Reset timing as it stands: tick an empty deque into idle, then store a
  // priority colour and a dark colour.
  task automatic test_power_up();
    send_word(ACT_TICK, COL_RED);
    send_word(ACT_PUSH, COL_RED);
    send_word(ACT_APPEND, COL_DARK);
  endtask

  // Zero timings; fill the deque to the brim, bounce requests off it, send the
  // no-op action, then tick.
  task automatic test_deque_edges();
    drain_results();
    apply_timing('0, '0, '0);
    for (int i = 0; i < 13; i++) send_word(ACT_APPEND, COLOUR_W'(i + 1));
    send_word(ACT_PUSH, COL_WHITE);
    send_word(ACT_APPEND, COL_RED);
    send_word(ACT_PUSH, COL_DARK);
    send_word(ACT_NONE, COL_DARK);
    repeat (3) send_word(ACT_TICK, COL_RED);
  endtask

  // Random words under a series of timings. Each phase draws its own mix: low
  // tick shares fill the deque, high ones drain it. Extremes run last, since a
  // maximal phase never ends within the run.
  task automatic test_random_timing();
    logic [TICK_W-1:0] on_t;
    logic [TICK_W-1:0] gap_t;
    logic [TICK_W-1:0] idle_t;
    int unsigned       tick_share;
    int unsigned       roll;
    action_t           act;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      // hold off until every report is in before touching the registers
      drain_results();
      on_t   = TICK_W'($urandom_range(0, 4));
      gap_t  = TICK_W'($urandom_range(0, 4));
      idle_t = TICK_W'($urandom_range(0, 4));
      case (p)
        0: begin on_t = 16'd1; gap_t = 16'd0; idle_t = 16'd0; end
        1: begin on_t = 16'd0; gap_t = 16'd1; idle_t = 16'd0; end
        3: begin on_t = 16'd2; gap_t = 16'd3; idle_t = 16'd1; end
        5: begin on_t = 16'd3; gap_t = 16'd0; idle_t = 16'd5; end
        PHASE_COUNT - 1: begin on_t = '1; gap_t = '1; idle_t = '1; end
        default: ;
      endcase
      apply_timing(on_t, gap_t, idle_t);
      tx_gaps_on   = (p % 3 != 1);
      rx_stalls_on = (p % 4 != 2);
      tick_share   = $urandom_range(30, 85);
      repeat (PHASE_WORDS) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) act = ACT_NONE;
        else if (roll < tick_share) act = ACT_TICK;
        else if ($urandom_range(0, 1) == 0) act = ACT_APPEND;
        else act = ACT_PUSH;
        send_word(act, COLOUR_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Take report words: compare each with the oldest expectation, then stall for
  // a drawn number of cycles before the next one.
  always @(posedge clk) begin : take_reports
    led_report_t want;
    if (rst) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (led_report_due.size() == 0) begin
          $error("report word with nothing expected");
          fault_count++;
        end else begin
          want = led_report_due[0];
          led_report_due.delete(0);
          check_field("accepted", want.accepted, accepted);
          check_field("queue_full", want.queue_full, queue_full);
          check_field("led_red", want.led_red, led_red);
          check_field("led_green", want.led_green, led_green);
          check_field("led_blue", want.led_blue, led_blue);
        end
        rx_hold = rx_stalls_on ? $urandom_range(0, 9) : 0;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold > 0);
    end
  end

  // Count cycles in which no word moves on either side; give up on a hang.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_power_up();
    test_deque_edges();
    test_random_timing();
    drain_results();
    // allow for a stray word after the last expected one
    repeat (8) @(posedge clk);
    if (fault_count == 0 && led_report_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
